// File: rtl/tpms_pkg.sv
// Package with the shared types and constants of the timed patrol motion sequencer.
`timescale 1ns / 1ps

package tpms_pkg;

  // Default parameter values.
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned AngleWidth  = 16;
  localparam int unsigned ZigzagLimit = 8;

  // Configuration port geometry.
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Width of the zig-zag counter.
  localparam int unsigned ZzCountWidth = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegForwardForce  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegMinDistance   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegTargetHeight  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegSwitchTime    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegBackwardTime  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegRotateTime    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegZigzagStep    = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegHeadingOffset = 3'd7;

  // Sequencer phase codes, also the action field of a result.
  localparam logic [1:0] ActForward  = 2'd0;
  localparam logic [1:0] ActBackward = 2'd1;
  localparam logic [1:0] ActRotate   = 2'd2;
  localparam logic [1:0] ActWait     = 2'd3;

  // Register reset values.
  localparam logic [31:0] SwitchTimeRst    = 32'd10000;
  localparam logic [31:0] BackwardTimeRst  = 32'd2000;
  localparam logic [31:0] RotateTimeRst    = 32'd2000;
  localparam logic [14:0] ZigzagStepRst    = 15'd2731;
  localparam logic [15:0] HeadingOffsetRst = 16'd1456;

  // Initial heading in degrees.
  localparam longint unsigned HeadingInitDeg = 295;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [15:0] fwd_thrust;
    logic        [15:0] stop_distance;
    logic signed [15:0] target_height;
    logic        [31:0] fwd_timeout;
    logic        [31:0] backward_time;
    logic        [31:0] rotate_time;
    logic        [14:0] zigzag_step;
    logic        [15:0] heading_offset;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic signed [16:0] force_res;
    logic signed [15:0] height;
    logic        [15:0] yaw_target;
    logic        [1:0]  action;
  } res_t;

endpackage

// File: rtl/tpms_if.sv
// Valid/ready channel interfaces for the step requests and the result items.
`timescale 1ns / 1ps

interface tpms_in_if #(
  parameter int unsigned TIME_WIDTH = tpms_pkg::TimeWidth
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [TIME_WIDTH-1:0]   now_ms;
  logic [15:0]             distance;
  logic signed [15:0]      yaw_measured;

  modport source (output valid, mode, now_ms, distance, yaw_measured, input ready);
  modport sink   (input valid, mode, now_ms, distance, yaw_measured, output ready);
endinterface

interface tpms_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] force_res;
  logic signed [15:0] height;
  logic        [15:0] yaw_target;
  logic        [1:0]  action;

  modport source (output valid, force_res, height, yaw_target, action, input ready);
  modport sink   (input valid, force_res, height, yaw_target, action, output ready);
endinterface

// File: rtl/tpms_step.sv
// Combinational step logic: phase transition, timer, zig-zag and result forming.
`timescale 1ns / 1ps

module tpms_step #(
  parameter int unsigned TIME_WIDTH   = tpms_pkg::TimeWidth,
  parameter int unsigned ANGLE_WIDTH  = tpms_pkg::AngleWidth,
  parameter int unsigned ZIGZAG_LIMIT = tpms_pkg::ZigzagLimit
) (
  input  tpms_pkg::cfg_t                      cfg_i,
  input  logic                                mode_i,
  input  logic [TIME_WIDTH-1:0]               now_ms_i,
  input  logic [15:0]                         distance_i,
  input  logic signed [15:0]                  yaw_measured_i,
  input  logic [1:0]                          action_i,
  input  logic [TIME_WIDTH-1:0]               timer_start_i,
  input  logic [tpms_pkg::ZzCountWidth-1:0]   zz_count_i,
  input  logic                                zz_neg_i,
  input  logic [ANGLE_WIDTH-1:0]              heading_i,
  output logic [1:0]                          action_o,
  output logic [TIME_WIDTH-1:0]               timer_start_o,
  output logic [tpms_pkg::ZzCountWidth-1:0]   zz_count_o,
  output logic                                zz_neg_o,
  output logic [ANGLE_WIDTH-1:0]              heading_o,
  output tpms_pkg::res_t                      res_o
);

  localparam int unsigned CmpWidth = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int unsigned IncWidth = tpms_pkg::ZzCountWidth + 1;
  localparam logic [IncWidth-1:0] Limit = IncWidth'(ZIGZAG_LIMIT);
  localparam logic [ANGLE_WIDTH-1:0] QTurn = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  localparam logic [ANGLE_WIDTH-1:0] TQTurn = QTurn + (QTurn << 1);

  logic [TIME_WIDTH-1:0]  elapsed;
  logic [CmpWidth-1:0]    elapsed_ext;
  logic                   fwd_end;
  logic                   bwd_end;
  logic                   wait_end;
  logic [IncWidth-1:0]    cnt_inc;
  logic [ANGLE_WIDTH-1:0] offset;
  logic [ANGLE_WIDTH-1:0] step;
  logic [ANGLE_WIDTH-1:0] base;
  logic                   sub_step;
  logic signed [17:0]     f_ext;
  logic signed [17:0]     neg3;

  // Elapsed time since the last restart, modulo the time width.
  assign elapsed     = now_ms_i - timer_start_i;
  assign elapsed_ext = CmpWidth'(elapsed);

  assign fwd_end  = (distance_i < cfg_i.stop_distance) ||
                    (elapsed_ext > CmpWidth'(cfg_i.fwd_timeout));
  assign bwd_end  = elapsed_ext > CmpWidth'(cfg_i.backward_time);
  assign wait_end = elapsed_ext > CmpWidth'(cfg_i.rotate_time);

  assign cnt_inc = IncWidth'(zz_count_i) + IncWidth'(1);

  // Phase sequencer with timer restart and zig-zag bookkeeping.
  always_comb begin
    action_o      = action_i;
    timer_start_o = timer_start_i;
    zz_count_o    = zz_count_i;
    zz_neg_o      = zz_neg_i;
    if (mode_i) begin
      timer_start_o = now_ms_i;
    end else begin
      unique case (action_i)
        tpms_pkg::ActForward: begin
          if (fwd_end) begin
            action_o      = tpms_pkg::ActBackward;
            timer_start_o = now_ms_i;
            if (cnt_inc > Limit) begin
              zz_count_o = '0;
              zz_neg_o   = !zz_neg_i;
            end else begin
              zz_count_o = cnt_inc[tpms_pkg::ZzCountWidth-1:0];
            end
          end
        end
        tpms_pkg::ActBackward: begin
          if (bwd_end) begin
            action_o      = tpms_pkg::ActRotate;
            timer_start_o = now_ms_i;
          end
        end
        tpms_pkg::ActRotate: begin
          action_o = tpms_pkg::ActWait;
        end
        tpms_pkg::ActWait: begin
          if (wait_end) begin
            action_o      = tpms_pkg::ActForward;
            timer_start_o = now_ms_i;
          end
        end
        default: begin
          action_o = action_i;
        end
      endcase
    end
  end

  // New heading on entering rotate: the zig-zag step is subtracted when the
  // measured yaw and the zig-zag direction disagree in sense.
  assign offset   = ANGLE_WIDTH'(cfg_i.heading_offset);
  assign step     = ANGLE_WIDTH'(cfg_i.zigzag_step);
  assign base     = ((yaw_measured_i > 16'sd0) ? TQTurn : QTurn) + offset;
  assign sub_step = (yaw_measured_i > 16'sd0) ? zz_neg_i : !zz_neg_i;

  always_comb begin
    heading_o = heading_i;
    if (!mode_i && action_o == tpms_pkg::ActRotate) begin
      heading_o = sub_step ? (base - step) : (base + step);
    end
  end

  // Backward thrust is floor(-1.5 * forward thrust).
  assign f_ext = 18'(cfg_i.fwd_thrust);
  assign neg3  = -(f_ext + (f_ext <<< 1));

  always_comb begin
    res_o.height     = cfg_i.target_height;
    res_o.yaw_target = 16'(heading_o);
    res_o.action     = action_o;
    case (action_o)
      tpms_pkg::ActForward:  res_o.force_res = 17'(cfg_i.fwd_thrust);
      tpms_pkg::ActBackward: res_o.force_res = neg3[17:1];
      default:               res_o.force_res = '0;
    endcase
  end

endmodule

// File: rtl/timed_patrol_motion_sequencer_unit.sv
// Top level of the timed patrol motion sequencer: registers, handshake and config port.
`timescale 1ns / 1ps

// A request is captured in the input register, and its result is loaded into the
// output register when the request leaves it; a start request gives no result.
// Throughput: one request per cycle while the output register is free or being read;
// the step logic between the input register and the output register is combinational.
// The output register lets a new request enter while a result waits to be taken.
// Reset (rst_ni low, asynchronous) clears the pipeline, the phase, timer and zig-zag
// state, and loads the configuration registers with their default values.
module timed_patrol_motion_sequencer_unit #(
  parameter int unsigned TIME_WIDTH   = tpms_pkg::TimeWidth,
  parameter int unsigned ANGLE_WIDTH  = tpms_pkg::AngleWidth,
  parameter int unsigned ZIGZAG_LIMIT = tpms_pkg::ZigzagLimit
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tpms_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tpms_pkg::CfgDataWidth-1:0]    cfg_data_i,
  tpms_in_if.sink                              in_req,
  tpms_out_if.source                           out_res
);

  localparam longint unsigned HeadInitFull =
      ((tpms_pkg::HeadingInitDeg << ANGLE_WIDTH) + 64'd180) / 64'd360;
  localparam logic [ANGLE_WIDTH-1:0] HeadInit = HeadInitFull[ANGLE_WIDTH-1:0];

  tpms_pkg::cfg_t cfg_q;

  // Input register.
  logic                    s1_valid_q;
  logic                    s1_mode_q;
  logic [TIME_WIDTH-1:0]   s1_now_q;
  logic [15:0]             s1_dist_q;
  logic signed [15:0]      s1_yaw_q;

  // Sequencer state.
  logic [1:0]                         action_q, action_d;
  logic [TIME_WIDTH-1:0]              timer_start_q, timer_start_d;
  logic [tpms_pkg::ZzCountWidth-1:0]  zz_count_q, zz_count_d;
  logic                               zz_neg_q, zz_neg_d;
  logic [ANGLE_WIDTH-1:0]             heading_q, heading_d;

  // Output register.
  logic           out_valid_q;
  tpms_pkg::res_t res_q;
  tpms_pkg::res_t res_d;

  logic s1_fire;
  logic out_load;
  logic in_fire;

  // A start request needs no output slot; a step request needs a free one.
  assign s1_fire  = s1_valid_q && (s1_mode_q || !out_valid_q || out_res.ready);
  assign out_load = s1_fire && !s1_mode_q;
  assign in_req.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_req.valid && in_req.ready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_thrust     <= '0;
      cfg_q.stop_distance  <= '0;
      cfg_q.target_height  <= '0;
      cfg_q.fwd_timeout    <= tpms_pkg::SwitchTimeRst;
      cfg_q.backward_time  <= tpms_pkg::BackwardTimeRst;
      cfg_q.rotate_time    <= tpms_pkg::RotateTimeRst;
      cfg_q.zigzag_step    <= tpms_pkg::ZigzagStepRst;
      cfg_q.heading_offset <= tpms_pkg::HeadingOffsetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpms_pkg::RegForwardForce:  cfg_q.fwd_thrust     <= signed'(cfg_data_i[15:0]);
        tpms_pkg::RegMinDistance:   cfg_q.stop_distance  <= cfg_data_i[15:0];
        tpms_pkg::RegTargetHeight:  cfg_q.target_height  <= signed'(cfg_data_i[15:0]);
        tpms_pkg::RegSwitchTime:    cfg_q.fwd_timeout    <= cfg_data_i[31:0];
        tpms_pkg::RegBackwardTime:  cfg_q.backward_time  <= cfg_data_i[31:0];
        tpms_pkg::RegRotateTime:    cfg_q.rotate_time    <= cfg_data_i[31:0];
        tpms_pkg::RegZigzagStep:    cfg_q.zigzag_step    <= cfg_data_i[14:0];
        tpms_pkg::RegHeadingOffset: cfg_q.heading_offset <= cfg_data_i[15:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_q <= in_req.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q <= in_req.mode;
      s1_now_q  <= in_req.now_ms;
      s1_dist_q <= in_req.distance;
      s1_yaw_q  <= in_req.yaw_measured;
    end
  end

  tpms_step #(
    .TIME_WIDTH  (TIME_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .ZIGZAG_LIMIT(ZIGZAG_LIMIT)
  ) u_step (
    .cfg_i         (cfg_q),
    .mode_i        (s1_mode_q),
    .now_ms_i      (s1_now_q),
    .distance_i    (s1_dist_q),
    .yaw_measured_i(s1_yaw_q),
    .action_i      (action_q),
    .timer_start_i (timer_start_q),
    .zz_count_i    (zz_count_q),
    .zz_neg_i      (zz_neg_q),
    .heading_i     (heading_q),
    .action_o      (action_d),
    .timer_start_o (timer_start_d),
    .zz_count_o    (zz_count_d),
    .zz_neg_o      (zz_neg_d),
    .heading_o     (heading_d),
    .res_o         (res_d)
  );

  // Sequencer state update when the request leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q      <= tpms_pkg::ActForward;
      timer_start_q <= '0;
      zz_count_q    <= '0;
      zz_neg_q      <= 1'b0;
      heading_q     <= HeadInit;
    end else if (s1_fire) begin
      action_q      <= action_d;
      timer_start_q <= timer_start_d;
      zz_count_q    <= zz_count_d;
      zz_neg_q      <= zz_neg_d;
      heading_q     <= heading_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_res.valid      = out_valid_q;
  assign out_res.force_res  = res_q.force_res;
  assign out_res.height     = res_q.height;
  assign out_res.yaw_target = res_q.yaw_target;
  assign out_res.action     = res_q.action;

endmodule

// File: bench/tb_timed_patrol_motion_sequencer_unit.sv
// Self-checking testbench of the timed patrol motion sequencer with its own command predictor.
`timescale 1ns / 1ps

module tb_timed_patrol_motion_sequencer_unit;

  // Request mode codes.
  localparam bit ModeStep  = 1'b0;
  localparam bit ModeStart = 1'b1;

  // The slowest correct run stays far below this.
  localparam int unsigned CycleLimit = 200000;

  // Tracks the patrol sequencer and holds the commands it must still produce.
  class patrol_scoreboard;
    localparam logic [15:0] QuarterTurn = 16'(1 << (tpms_pkg::AngleWidth - 2));
    localparam logic [15:0] HeadingInit =
      16'(((tpms_pkg::HeadingInitDeg << tpms_pkg::AngleWidth) + 64'd180) / 64'd360);

    // Copy of the configuration registers.
    logic signed [15:0] fwd_force;
    logic        [15:0] min_dist;
    logic signed [15:0] tgt_height;
    logic        [31:0] switch_ms;
    logic        [31:0] backward_ms;
    logic        [31:0] rotate_ms;
    logic        [14:0] zz_step;
    logic        [15:0] hdg_offset;

    // Sequencer state.
    logic [1:0]  phase;
    logic [31:0] timer_start;
    logic [3:0]  zz_count;
    bit          zz_neg;
    logic [15:0] heading;

    tpms_pkg::res_t pending_cmds[$];
    int unsigned    mismatches;

    function new();
      fwd_force   = '0;
      min_dist    = '0;
      tgt_height  = '0;
      switch_ms   = tpms_pkg::SwitchTimeRst;
      backward_ms = tpms_pkg::BackwardTimeRst;
      rotate_ms   = tpms_pkg::RotateTimeRst;
      zz_step     = tpms_pkg::ZigzagStepRst;
      hdg_offset  = tpms_pkg::HeadingOffsetRst;
      phase       = tpms_pkg::ActForward;
      timer_start = '0;
      zz_count    = '0;
      zz_neg      = 1'b0;
      heading     = HeadingInit;
      mismatches  = 0;
    endfunction

    // Registers keep only the bits of their own width.
    function void write_reg(logic [tpms_pkg::CfgIdxWidth-1:0] idx, logic [31:0] data);
      case (idx)
        tpms_pkg::RegForwardForce:  fwd_force   = data[15:0];
        tpms_pkg::RegMinDistance:   min_dist    = data[15:0];
        tpms_pkg::RegTargetHeight:  tgt_height  = data[15:0];
        tpms_pkg::RegSwitchTime:    switch_ms   = data;
        tpms_pkg::RegBackwardTime:  backward_ms = data;
        tpms_pkg::RegRotateTime:    rotate_ms   = data;
        tpms_pkg::RegZigzagStep:    zz_step     = data[14:0];
        tpms_pkg::RegHeadingOffset: hdg_offset  = data[15:0];
        default: ;
      endcase
    endfunction

    // Advance the sequencer by one accepted request and queue the command it yields.
    function void note_request(bit is_start, logic [31:0] now, logic [15:0] dist_v,
                               logic signed [15:0] yaw);
      logic [31:0]        elapsed;
      logic signed [17:0] triple;
      int unsigned        cnt;
      tpms_pkg::res_t     cmd;
      if (is_start) begin
        timer_start = now;
        return;
      end
      elapsed = now - timer_start;

      // Phase transitions; rotate to wait keeps the timer running.
      case (phase)
        tpms_pkg::ActForward: if (dist_v < min_dist || elapsed > switch_ms) begin
          phase       = tpms_pkg::ActBackward;
          timer_start = now;
          cnt         = zz_count + 1;
          if (cnt > tpms_pkg::ZigzagLimit) begin
            cnt    = 0;
            zz_neg = !zz_neg;
          end
          zz_count = 4'(cnt);
        end
        tpms_pkg::ActBackward: if (elapsed > backward_ms) begin
          phase       = tpms_pkg::ActRotate;
          timer_start = now;
        end
        tpms_pkg::ActRotate: phase = tpms_pkg::ActWait;
        default: if (elapsed > rotate_ms) begin
          phase       = tpms_pkg::ActForward;
          timer_start = now;
        end
      endcase

      // Command of the phase just entered or held.
      cmd.force_res = '0;
      case (phase)
        tpms_pkg::ActForward: cmd.force_res = 17'(fwd_force);
        tpms_pkg::ActBackward: begin
          // Minus one and a half times the thrust, rounded toward minus infinity.
          triple        = -(18'(fwd_force) * 18'sd3);
          cmd.force_res = 17'(triple >>> 1);
        end
        tpms_pkg::ActRotate: begin
          if (yaw > 16'sd0) begin
            heading = 16'(3 * QuarterTurn) + hdg_offset;
            heading = zz_neg ? heading - {1'b0, zz_step} : heading + {1'b0, zz_step};
          end else begin
            heading = QuarterTurn + hdg_offset;
            heading = zz_neg ? heading + {1'b0, zz_step} : heading - {1'b0, zz_step};
          end
        end
        default: ;
      endcase
      cmd.height     = tgt_height;
      cmd.yaw_target = heading;
      cmd.action     = phase;
      pending_cmds.push_back(cmd);
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest expected command.
    task check_result(tpms_pkg::res_t got);
      tpms_pkg::res_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("result with none expected, action %0d", got.action));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.force_res !== want.force_res)
        report($sformatf("force_res %0d, expected %0d", got.force_res, want.force_res));
      if (got.height !== want.height)
        report($sformatf("height %0d, expected %0d", got.height, want.height));
      if (got.yaw_target !== want.yaw_target)
        report($sformatf("yaw_target %0d, expected %0d", got.yaw_target, want.yaw_target));
      if (got.action !== want.action)
        report($sformatf("action %0d, expected %0d", got.action, want.action));
    endtask
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [tpms_pkg::CfgIdxWidth-1:0]  cfg_idx_i;
  logic [tpms_pkg::CfgDataWidth-1:0] cfg_data_i;

  tpms_in_if  req_ch ();
  tpms_out_if res_ch ();

  timed_patrol_motion_sequencer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req     (req_ch),
    .out_res    (res_ch)
  );

  patrol_scoreboard sb;
  bit               tx_stall_on;
  bit               rx_stall_on;
  logic [31:0]      clock_ms;
  int unsigned      cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Run-away guard.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timed_patrol_motion_sequencer_unit test failed");
    $finish;
  end

  // Write one register; the caller lowers the write enable after its last write.
  task write_reg(logic [tpms_pkg::CfgIdxWidth-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task program_regs(logic [31:0] force_v, logic [31:0] min_v, logic [31:0] height_v,
                    logic [31:0] switch_v, logic [31:0] backward_v, logic [31:0] rotate_v,
                    logic [31:0] step_v, logic [31:0] offset_v);
    write_reg(tpms_pkg::RegForwardForce, force_v);
    write_reg(tpms_pkg::RegMinDistance, min_v);
    write_reg(tpms_pkg::RegTargetHeight, height_v);
    write_reg(tpms_pkg::RegSwitchTime, switch_v);
    write_reg(tpms_pkg::RegBackwardTime, backward_v);
    write_reg(tpms_pkg::RegRotateTime, rotate_v);
    write_reg(tpms_pkg::RegZigzagStep, step_v);
    write_reg(tpms_pkg::RegHeadingOffset, offset_v);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one request and return at the edge that accepts it.
  task send_req(bit mode, logic [31:0] now, logic [15:0] dist_v, logic signed [15:0] yaw);
    int unsigned gap;
    bit          taken;
    gap = tx_stall_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= mode;
    req_ch.now_ms       <= now;
    req_ch.distance     <= dist_v;
    req_ch.yaw_measured <= yaw;
    do begin
      @(negedge clk_i);
      taken = req_ch.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_request(mode == ModeStart, now, dist_v, yaw);
  endtask

  // Stop sending until every expected command has come back.
  task hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Let a trailing start request leave the pipeline too.
  task wait_idle();
    hold_until_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // Random requests around the current distance threshold with a slowly advancing clock.
  task run_random(int count, int unsigned step_max, bit force_pause);
    bit                 mode;
    logic [15:0]        dist_v;
    logic signed [15:0] yaw;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 2) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      mode = ($urandom_range(0, 15) == 0) ? ModeStart : ModeStep;
      if ($urandom_range(0, 3) == 0) dist_v = 16'($urandom);
      else dist_v = sb.min_dist + 16'($urandom_range(0, 48)) - 16'd16;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: yaw = 16'sd0;
          1: yaw = 16'sd1;
          2: yaw = -16'sd1;
          3: yaw = 16'sh7FFF;
          default: yaw = 16'sh8000;
        endcase
      end else begin
        yaw = 16'($urandom);
      end
      send_req(mode, clock_ms, dist_v, yaw);
      if ((force_pause && i == count / 2) || $urandom_range(0, 149) == 0)
        hold_until_drained();
    end
  endtask

  // Result side: random stalls, payload sampled at the falling edge.
  initial begin
    int unsigned    gap;
    bit             seen;
    tpms_pkg::res_t snap;
    res_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      gap = rx_stall_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen           = res_ch.valid;
        snap.force_res = res_ch.force_res;
        snap.height    = res_ch.height;
        snap.yaw_target = res_ch.yaw_target;
        snap.action    = res_ch.action;
        @(posedge clk_i);
      end while (seen !== 1'b1);
      sb.check_result(snap);
    end
  end

  // Main sequence.
  initial begin
    sb                  = new();
    tx_stall_on         = 1'b1;
    rx_stall_on         = 1'b1;
    clock_ms            = '0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= ModeStep;
    req_ch.now_ms       <= '0;
    req_ch.distance     <= '0;
    req_ch.yaw_measured <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through all phases with the reset configuration.
    send_req(ModeStep, 32'd0, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd10000, 16'hFFFF, 16'sd1);
    send_req(ModeStep, 32'd10001, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd12001, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd12002, 16'd0, 16'sh7FFF);
    send_req(ModeStep, 32'd12002, 16'd0, 16'sd0);
    // Start just before the clock wraps, so the next elapsed time spans the wrap.
    send_req(ModeStart, 32'hFFFF_FF00, 16'hFFFF, 16'sh8000);
    send_req(ModeStep, 32'h0000_06D0, 16'd0, 16'sd0);
    send_req(ModeStep, 32'h0000_06D1, 16'd0, 16'sd0);
    wait_idle();

    // Extreme settings: most negative thrust, full-width offsets, forward ends on distance.
    program_regs(32'hFFFF_8000, 32'd100, 32'd32767, 32'hFFFF_FFFF, 32'd0, 32'd0,
                 32'd32767, 32'd65535);
    send_req(ModeStep, 32'd100, 16'd99, 16'sd0);
    send_req(ModeStep, 32'd100, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd101, 16'd0, 16'sh8000);
    send_req(ModeStep, 32'd101, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd102, 16'd100, 16'sd0);
    send_req(ModeStep, 32'hFFFF_FFFF, 16'd100, 16'sd0);
    send_req(ModeStep, 32'd103, 16'd0, 16'sd1);
    send_req(ModeStep, 32'd104, 16'd0, 16'sd1);
    send_req(ModeStep, 32'd104, 16'd0, 16'sd0);
    send_req(ModeStart, 32'd0, 16'd0, 16'sd0);
    send_req(ModeStep, 32'd1, 16'd0, 16'sd0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      tx_stall_on = (p % 3 != 1);
      rx_stall_on = (p % 4 != 2);
      case (p)
        0: program_regs(32'h0000_7FFF, 32'd0, 32'hFFFF_8000, 32'd0, 32'd0, 32'd0,
                        32'd0, 32'd0);
        1: program_regs(32'hFFFF_8000, 32'd65535, 32'd32767, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: program_regs($urandom, $urandom, $urandom, $urandom_range(0, 60),
                              $urandom_range(0, 20), $urandom_range(0, 20), $urandom,
                              $urandom);
      endcase
      case (p)
        0: run_random(200, 3, 1'b0);
        1: run_random(40, 8, 1'b0);
        default: run_random(225, 8, p == 3);
      endcase
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("timed_patrol_motion_sequencer_unit test passed");
    end else begin
      $display("timed_patrol_motion_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tpms_pkg.sv
rtl/tpms_if.sv
rtl/tpms_step.sv
rtl/timed_patrol_motion_sequencer_unit.sv
bench/tb_timed_patrol_motion_sequencer_unit.sv
